// File: hw/rtl/cs_pkg.sv
// Shared types and constants for the comment stripper.
// Used by cs_step, cs_result_fifo and comment_stripper_core; no dependencies.
`default_nettype none

package cs_pkg;

  // Character codes that the scanner looks for
  localparam logic [7:0] CharSlash   = 8'h2F;
  localparam logic [7:0] CharStar    = 8'h2A;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSpace   = 8'h20;

  // Scanner mode codes (the codes above ModeBlockStar are unused and act as normal text)
  localparam logic [2:0] ModeNormal    = 3'd0;
  localparam logic [2:0] ModeSlash     = 3'd1;
  localparam logic [2:0] ModeLine      = 3'd2;
  localparam logic [2:0] ModeBlock     = 3'd3;
  localparam logic [2:0] ModeBlockStar = 3'd4;

  // Result queue sizing: room for two results from each step
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // One result transaction
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_present;
    logic       last_of_run;
    logic       open_comment_error;
  } result_t;

  // Everything one input character produces
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } step_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/cs_step.sv
// Scanner state and per-character step logic of the comment stripper.
// Depends on cs_pkg.
`default_nettype none

module cs_step (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_en_i,
  input  wire logic [7:0]        char_i,
  input  wire logic              eos_i,
  output cs_pkg::step_out_t      step_o
);
  import cs_pkg::*;

  logic [2:0] mode_q, mode_d;
  logic       spanned_q, spanned_d;

  // Step logic: mode update plus up to two kept characters
  always_comb begin
    logic [2:0] mode_n;
    logic       span_n;
    logic [1:0] n;
    logic [7:0] e0;
    logic [7:0] e1;
    logic       err;

    mode_n = mode_q;
    span_n = spanned_q;
    n      = 2'd0;
    e0     = 8'h00;
    e1     = 8'h00;
    err    = 1'b0;

    case (mode_q)
      ModeSlash: begin
        if (char_i == CharSlash) begin
          mode_n = ModeLine;
        end else if (char_i == CharStar) begin
          mode_n = ModeBlock;
          span_n = 1'b0;
        end else begin
          // held slash released, then the character as normal text
          mode_n = ModeNormal;
          n      = 2'd2;
          e0     = CharSlash;
          e1     = char_i;
        end
      end
      ModeLine: begin
        if (char_i == CharNewline) begin
          n      = 2'd1;
          e0     = CharNewline;
          mode_n = ModeNormal;
        end
      end
      ModeBlock: begin
        if (char_i == CharNewline) begin
          n      = 2'd1;
          e0     = CharNewline;
          span_n = 1'b1;
        end else if (char_i == CharStar) begin
          mode_n = ModeBlockStar;
        end
      end
      ModeBlockStar: begin
        if (char_i == CharSlash) begin
          // comment closed on its own line collapses to one space
          if (!spanned_q) begin
            n  = 2'd1;
            e0 = CharSpace;
          end
          mode_n = ModeNormal;
          span_n = 1'b0;
        end else if (char_i == CharNewline) begin
          n      = 2'd1;
          e0     = CharNewline;
          span_n = 1'b1;
          mode_n = ModeBlock;
        end else if (char_i != CharStar) begin
          mode_n = ModeBlock;
        end
      end
      default: begin
        if (char_i == CharSlash) begin
          mode_n = ModeSlash;
        end else begin
          mode_n = ModeNormal;
          n      = 2'd1;
          e0     = char_i;
        end
      end
    endcase

    // End of source: flush held slash, flag open block comment, back to reset
    if (eos_i) begin
      if (mode_n == ModeSlash) begin
        n  = 2'd1;
        e0 = CharSlash;
      end
      err    = (mode_n == ModeBlock) || (mode_n == ModeBlockStar);
      mode_n = ModeNormal;
      span_n = 1'b0;
    end

    mode_d    = mode_n;
    spanned_d = span_n;

    // Pack results
    step_o.res0.out_char           = e0;
    step_o.res0.char_present       = (n != 2'd0);
    step_o.res0.last_of_run        = (n != 2'd2);
    step_o.res0.open_comment_error = err && (n != 2'd2);
    step_o.res1.out_char           = e1;
    step_o.res1.char_present       = 1'b1;
    step_o.res1.last_of_run        = 1'b1;
    step_o.res1.open_comment_error = err;
    if (n == 2'd0) begin
      step_o.num = err ? 2'd1 : 2'd0;
    end else begin
      step_o.num = n;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeNormal;
      spanned_q <= 1'b0;
    end else if (step_en_i) begin
      mode_q    <= mode_d;
      spanned_q <= spanned_d;
    end
  end

  // Checks
  a_two_only_from_slash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && (step_o.num == 2'd2) |-> (mode_q == ModeSlash))
    else $error("two results without a held slash");

  a_eos_returns_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && eos_i |=> (mode_q == ModeNormal) && !spanned_q)
    else $error("state not reset after end of source");

  a_spanned_only_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spanned_q |-> (mode_q == ModeBlock) || (mode_q == ModeBlockStar))
    else $error("spanned flag set outside block comment");

endmodule

`default_nettype wire

// File: hw/rtl/cs_result_fifo.sv
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on cs_pkg.
`default_nettype none

module cs_result_fifo (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [1:0]                    push_num_i,
  input  wire cs_pkg::result_t               push_res0_i,
  input  wire cs_pkg::result_t               push_res1_i,
  input  wire logic                          pop_i,
  output cs_pkg::result_t                    head_o,
  output logic [cs_pkg::FifoCntW-1:0]        count_o
);
  import cs_pkg::*;

  result_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   count_q, count_d;
  logic [FifoPtrW-1:0]   wr_ptr_nxt;

  assign wr_ptr_nxt = wr_ptr_q + FifoPtrW'(1);

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_num_i);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop_i);
    count_d  = count_q + FifoCntW'(push_num_i) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage writes
  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_res0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_res1_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FifoCntW'(push_num_i) + count_q <= FifoCntW'(FifoDepth) + FifoCntW'(pop_i))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("pop from empty result queue");

  a_ptr_count_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) || (count_q == FifoCntW'(FifoDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers disagree with fill count");

endmodule

`default_nettype wire

// File: hw/rtl/comment_stripper_core.sv
// Comment stripper, top level: input register, scanner step, result queue.
// An input transaction passes the input register and the result queue before its first result transaction.
// Throughput: one character per cycle; a step with two results gives two output transactions.
// The input stage holds while the result queue lacks room for two results.
// Reset (async, active low) returns the scanner to normal text and empties the queue.
// Depends on cs_pkg, cs_step and cs_result_fifo.
`default_nettype none

module comment_stripper_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       end_of_source_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_char_o,
  output logic            char_present_o,
  output logic            last_of_run_o,
  output logic            open_comment_error_o
);
  import cs_pkg::*;

  logic                in_valid_q, in_valid_d;
  logic [7:0]          char_q;
  logic                eos_q;
  logic                in_accept;
  logic                advance;
  logic [FifoCntW-1:0] fifo_count;
  step_out_t           step;
  result_t             head;
  logic [1:0]          push_num;
  logic                pop;

  // Input stage moves on when the queue has room for two results
  assign advance    = in_valid_q && (fifo_count <= FifoCntW'(FifoDepth - 2));
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= in_char_i;
      eos_q  <= end_of_source_i;
    end
  end

  cs_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .char_i    (char_q),
    .eos_i     (eos_q),
    .step_o    (step)
  );

  assign push_num = advance ? step.num : 2'd0;
  assign pop      = out_valid_o && !out_stall_i;

  cs_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .push_res0_i (step.res0),
    .push_res1_i (step.res1),
    .pop_i       (pop),
    .head_o      (head),
    .count_o     (fifo_count)
  );

  // Output transaction
  assign out_valid_o          = (fifo_count != '0);
  assign out_char_o           = head.out_char;
  assign char_present_o       = head.char_present;
  assign last_of_run_o        = head.last_of_run;
  assign open_comment_error_o = head.open_comment_error;

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> fifo_count > FifoCntW'(FifoDepth - 2))
    else $error("input stalled with room in the queue");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(char_q) && $stable(eos_q))
    else $error("held input item lost");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && open_comment_error_o |-> last_of_run_o)
    else $error("error flag on a result that is not last");

endmodule

`default_nettype wire
